// ===== design/cal2ep_pkg.sv =====
// ----------------------------------------------------------------------------
// cal2ep_pkg: shared constants and calendar tables
// Field widths, epoch constants and month lookup functions for the
// calendar to epoch seconds converter.
// ----------------------------------------------------------------------------
package cal2ep_pkg;

    localparam int unsigned SecW    = 6;
    localparam int unsigned MinW    = 6;
    localparam int unsigned HourW   = 5;
    localparam int unsigned DayW    = 5;
    localparam int unsigned MonW    = 4;
    localparam int unsigned YearW   = 12;
    localparam int unsigned InBits  = SecW + MinW + HourW + DayW + MonW + YearW;
    localparam int unsigned InDataW = ((InBits + 7) / 8) * 8;

    localparam int unsigned EsecW   = 32;
    localparam int unsigned EminW   = 26;
    localparam int unsigned WdayW   = 3;
    localparam int unsigned OutBits = EsecW + EminW + WdayW;
    localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

    localparam int unsigned YyW     = 7;
    localparam int unsigned DaysW   = 16;

    localparam logic [YearW-1:0] BaseYear    = YearW'(2000);
    localparam logic [YearW-1:0] LastYear    = YearW'(2099);
    localparam logic [16:0]      SecsPerDay  = 17'd86400;
    localparam logic [11:0]      SecsPerHour = 12'd3600;
    localparam logic [10:0]      MinsPerDay  = 11'd1440;
    localparam logic [DaysW-1:0] BaseWeekday = DaysW'(6);
    // floor(x / 7) == (x * Recip7) >> Recip7Sh for x below 2**16
    localparam logic [16:0]      Recip7      = 17'd74899;
    localparam int unsigned      Recip7Sh    = 19;

    localparam logic [MonW-1:0]  MonJan = MonW'(1);
    localparam logic [MonW-1:0]  MonFeb = MonW'(2);
    localparam logic [MonW-1:0]  MonDec = MonW'(12);

    // days in the month for a common year; 0 for month codes with no meaning
    function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] mon);
        logic [DayW-1:0] len;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MonW-1:0] mon);
        logic [8:0] d;
        unique case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/calendar_to_epoch_seconds_core.sv =====
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_core: calendar time to seconds since 2000-01-01
// A request passes the input register, then one pass of conversion into the result register.
// Throughput one request per cycle; while a result waits downstream the input register
// takes one more request, then the input is held off until the result is taken.
// Synchronous active-low reset clears both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds_core
    import cal2ep_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // second[5:0], minute[11:6], hour[16:12], day_of_month[21:17], month[25:22],
    // year[37:26], zero fill above
    input  logic [InDataW-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // epoch_seconds[31:0], epoch_minutes[57:32], weekday[60:58], zero fill above
    output logic [OutDataW-1:0] o_m_axis_tdata,
    // time_valid
    output logic                o_m_axis_tuser
);

    logic                r_in_valid;
    logic [InBits-1:0]   r_in_data;
    logic                r_out_valid;
    logic [OutBits-1:0]  r_out_data;
    logic                r_out_ok;

    logic                out_adv;
    logic                in_take;

    logic [SecW-1:0]     sec;
    logic [MinW-1:0]     mnt;
    logic [HourW-1:0]    hr;
    logic [DayW-1:0]     dom;
    logic [MonW-1:0]     mon;
    logic [YearW-1:0]    yr;

    logic                leap;
    logic [DayW-1:0]     lim;
    logic                ok;
    logic [YearW-1:0]    yr_off;
    logic [YyW-1:0]      yy;
    logic [DaysW-1:0]    days;
    logic [SecW-1:0]     sec_m;
    logic [MinW-1:0]     mnt_m;
    logic [HourW-1:0]    hr_m;
    logic [32:0]         day_secs;
    logic [26:0]         day_mins;
    logic [EsecW-1:0]    n_secs;
    logic [EminW-1:0]    n_mins;
    logic [DaysW-1:0]    wd_x;
    logic [32:0]         wd_prod;
    logic [DaysW-1:0]    wd_q;
    logic [DaysW-1:0]    wd_r;
    logic [WdayW-1:0]    n_wday;

    assign out_adv         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_adv;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    assign {yr, mon, dom, hr, mnt, sec} = r_in_data;

    always_comb begin
        leap   = (yr[1:0] == 2'b00);
        lim    = (mon == MonFeb && leap) ? 5'd29 : month_len(mon);
        ok     = (sec <= SecW'(59)) && (mnt <= MinW'(59)) && (hr <= HourW'(23))
              && (mon >= MonJan) && (mon <= MonDec)
              && (yr >= BaseYear) && (yr <= LastYear)
              && (dom != '0) && (dom <= lim);
        yr_off = yr - BaseYear;
        yy     = yr_off[YyW-1:0];

        // zero the whole count on an invalid time
        if (ok) begin
            days = DaysW'(yy) * DaysW'(365) + DaysW'((yy + YyW'(3)) >> 2)
                 + DaysW'(days_before(mon))
                 + DaysW'((mon > MonFeb && leap) ? 1'b1 : 1'b0)
                 + DaysW'(dom - DayW'(1));
            sec_m = sec;
            mnt_m = mnt;
            hr_m  = hr;
        end else begin
            days  = '0;
            sec_m = '0;
            mnt_m = '0;
            hr_m  = '0;
        end

        day_secs = 33'(days) * 33'(SecsPerDay);
        day_mins = 27'(days) * 27'(MinsPerDay);
        n_secs   = day_secs[EsecW-1:0] + EsecW'(hr_m) * EsecW'(SecsPerHour)
                 + EsecW'(mnt_m) * EsecW'(60) + EsecW'(sec_m);
        n_mins   = day_mins[EminW-1:0] + EminW'(hr_m) * EminW'(60) + EminW'(mnt_m);

        // weekday = (days + 6) mod 7, with 0 shown as 7
        wd_x    = days + BaseWeekday;
        wd_prod = 33'(wd_x) * 33'(Recip7);
        wd_q    = DaysW'(wd_prod >> Recip7Sh);
        wd_r    = wd_x - ((wd_q << 3) - wd_q);
        n_wday  = (wd_r[WdayW-1:0] == '0) ? WdayW'(7) : wd_r[WdayW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_s_axis_tdata[InBits-1:0];
        end
        if (out_adv && r_in_valid) begin
            r_out_data <= {n_wday, n_mins, n_secs};
            r_out_ok   <= ok;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OutDataW'(r_out_data);
    assign o_m_axis_tuser  = r_out_ok;

`ifndef ASSERT_OFF
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !r_in_valid)
        else $error("valid flags not cleared by reset");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            r_out_data[EsecW-1:0] == '0 && r_out_data[EsecW+EminW-1:EsecW] == '0
            && r_out_data[OutBits-1:EsecW+EminW] == WdayW'(6))
        else $error("invalid time must give zero count and Saturday");

    a_min_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (34'(r_out_data[EsecW+EminW-1:EsecW]) * 34'(60) <= 34'(r_out_data[EsecW-1:0]))
            && (34'(r_out_data[EsecW+EminW-1:EsecW]) * 34'(60) + 34'(59)
                >= 34'(r_out_data[EsecW-1:0])))
        else $error("minute count does not match second count");

    a_wday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_out_data[OutBits-1:EsecW+EminW] != '0)
        else $error("weekday zero");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_m_axis_tvalid |=> o_m_axis_tvalid)
        else $error("request lost between stages");
`endif

endmodule
